[rtl/core/lzss_window_decompressor_macros.svh]
// Assertion macros used by the decompressor datapath.
`ifndef LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZSS_WINDOW_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, checked on clk, disabled in reset.
`define LWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwd check failed");

// Next-cycle implication, checked on clk, disabled in reset.
`define LWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwd check failed");

`endif

[rtl/core/lwd_pkg.sv]
// Shared widths and controller/datapath interface types for the LZSS decoder.
`timescale 1ns / 1ps
package lwd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_ADDR_W  = $clog2(WINDOW_SIZE);
    localparam int LEN_W       = 5;

    typedef struct packed {
        logic clr_wr;
        logic lit_wr;
        logic tok_lo_ld;
        logic copy_start;
        logic copy_step;
        logic end_ld;
    } lwd_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
        logic copy_last;
        logic src_zero;
    } lwd_sts_t;

endpackage

[rtl/core/lwd_ctrl.sv]
// Controller: window clear sequencing, flag tracking, item parsing and copy control.
`timescale 1ns / 1ps
module lwd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  lwd_pkg::lwd_sts_t sts,
    output lwd_pkg::lwd_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_COPY  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_ITEM = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] flag_bits_reg, flag_bits_next;
    logic [7:0] flag_sel_reg, flag_sel_next;
    logic       accept;

    assign in_ready = ((state_reg == ST_IDLE) && sts.out_free) || (state_reg == ST_DONE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        flag_bits_next = flag_bits_reg;
        flag_sel_next  = flag_sel_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        PH_ITEM:
                        begin
                            if ((flag_sel_reg & flag_bits_reg) == 8'd0)
                            begin
                                cmd.lit_wr = 1'b1;
                                if (flag_sel_reg[7])
                                begin
                                    flag_sel_next = 8'd1;
                                    phase_next    = PH_FLAG;
                                end
                                else
                                begin
                                    flag_sel_next = {flag_sel_reg[6:0], 1'b0};
                                end
                            end
                            else
                            begin
                                cmd.tok_lo_ld = 1'b1;
                                phase_next    = PH_HIGH;
                            end
                        end
                        PH_HIGH:
                        begin
                            if (sts.src_zero)
                            begin
                                cmd.end_ld = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cmd.copy_start = 1'b1;
                                state_next     = ST_COPY;
                            end
                        end
                        default:
                        begin
                            flag_bits_next = in_byte;
                            flag_sel_next  = 8'd1;
                            phase_next     = PH_ITEM;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (sts.out_free)
                begin
                    cmd.copy_step = 1'b1;
                    if (sts.copy_last)
                    begin
                        state_next = ST_IDLE;
                        if (flag_sel_reg[7])
                        begin
                            flag_sel_next = 8'd1;
                            phase_next    = PH_FLAG;
                        end
                        else
                        begin
                            flag_sel_next = {flag_sel_reg[6:0], 1'b0};
                            phase_next    = PH_ITEM;
                        end
                    end
                end
            end
            default:
            begin
                // finished: beats are taken and dropped until reset
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            phase_reg     <= PH_FLAG;
            flag_bits_reg <= 8'd0;
            flag_sel_reg  <= 8'd1;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            flag_bits_reg <= flag_bits_next;
            flag_sel_reg  <= flag_sel_next;
        end
    end

endmodule

[rtl/core/lwd_datapath.sv]
// Datapath: window memory, pointers, copy counter, read bypass and output register.
`timescale 1ns / 1ps
`include "lzss_window_decompressor_macros.svh"
module lwd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  lwd_pkg::lwd_cmd_t cmd,
    output lwd_pkg::lwd_sts_t sts,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              last,
    output logic              end_of_stream
);

    logic [7:0] window_mem [lwd_pkg::WINDOW_SIZE];

    logic [lwd_pkg::WIN_ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [lwd_pkg::WIN_ADDR_W-1:0] wr_pos_reg, wr_pos_next;
    logic [lwd_pkg::WIN_ADDR_W-1:0] src_reg, src_next;
    logic [lwd_pkg::LEN_W-1:0]      cnt_reg, cnt_next;
    logic [7:0]                     tok_lo_reg;
    logic [7:0]                     rd_q_reg;
    logic                           byp_hit_reg;
    logic [7:0]                     byp_data_reg;
    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           last_reg;
    logic                           eos_reg;

    logic [lwd_pkg::WIN_ADDR_W-1:0] tok_src;
    logic [lwd_pkg::WIN_ADDR_W-1:0] wr_addr;
    logic [lwd_pkg::WIN_ADDR_W-1:0] rd_addr;
    logic [7:0]                     wr_data;
    logic [7:0]                     copy_data;
    logic                           wr_en;
    logic                           rd_en;
    logic                           out_load;

    assign tok_src   = {in_byte, tok_lo_reg[7:4]};
    assign copy_data = byp_hit_reg ? byp_data_reg : rd_q_reg;

    assign sts.clr_done  = (clr_cnt_reg == lwd_pkg::WIN_ADDR_W'(lwd_pkg::WINDOW_SIZE - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.copy_last = (cnt_reg == lwd_pkg::LEN_W'(1));
    assign sts.src_zero  = (tok_src == '0);

    assign wr_en   = cmd.clr_wr || cmd.lit_wr || cmd.copy_step;
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : wr_pos_reg;
    assign wr_data = cmd.clr_wr ? 8'd0 : (cmd.lit_wr ? in_byte : copy_data);
    assign rd_en   = cmd.copy_start || (cmd.copy_step && !sts.copy_last);
    assign rd_addr = cmd.copy_start ? tok_src : src_reg;

    assign out_load = cmd.lit_wr || cmd.copy_step || cmd.end_ld;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        wr_pos_next  = wr_pos_reg;
        src_next     = src_reg;
        cnt_next     = cnt_reg;
        if (cmd.clr_wr)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.lit_wr || cmd.copy_step)
        begin
            wr_pos_next = wr_pos_reg + 1'b1;
        end
        if (cmd.copy_start)
        begin
            src_next = tok_src + 1'b1;
            cnt_next = {1'b0, tok_lo_reg[3:0]} + lwd_pkg::LEN_W'(2);
        end
        else if (cmd.copy_step)
        begin
            src_next = src_reg + 1'b1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= window_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tok_lo_ld)
        begin
            tok_lo_reg <= in_byte;
        end
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
        if (out_load)
        begin
            out_byte_reg <= cmd.copy_step ? copy_data : (cmd.lit_wr ? in_byte : 8'd0);
            last_reg     <= cmd.copy_step ? sts.copy_last : 1'b1;
            eos_reg      <= cmd.end_ld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            wr_pos_reg    <= lwd_pkg::WIN_ADDR_W'(1);
            src_reg       <= '0;
            cnt_reg       <= '0;
            byp_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            wr_pos_reg  <= wr_pos_next;
            src_reg     <= src_next;
            cnt_reg     <= cnt_next;
            if (rd_en)
            begin
                // read and write of one address in the same cycle: take the new byte
                byp_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last          = last_reg;
    assign end_of_stream = eos_reg;

    `LWD_ASSERT_NOW(a_one_cmd, 1'b1, $countones(cmd) <= 1)
    `LWD_ASSERT_NOW(a_no_overwrite, out_valid_reg && !out_ready, !out_load)
    `LWD_ASSERT_NOW(a_copy_count, cmd.copy_step, cnt_reg != '0)
    `LWD_ASSERT_NEXT(a_copy_read, cmd.copy_start, cnt_reg >= lwd_pkg::LEN_W'(2))

endmodule

[rtl/core/lzss_window_decompressor.sv]
// LZSS decompressor top level: 4096-byte window, byte stream in, byte stream out.
//
// Input channel in_valid/in_ready/in_byte carries the compressed stream, one byte
// per beat. Output channel out_valid/out_ready carries out_byte, last and
// end_of_stream, one decompressed byte per beat; last marks the final result
// caused by an input byte, end_of_stream marks the single end result.
// After reset the window is cleared one entry a cycle, all 4096 entries, while
// in_ready stays low.
// Flag bytes and token low bytes give no result. A literal shows on the output
// in the cycle after its beat. A match token high byte has its first copied
// byte read into a read register, then into the output register; then one byte
// per cycle unless the output stalls, with in_ready low until the last copied
// byte. The window memory port, one read and one write a cycle, sets the pace.
// Results sit in an output register; while the receiver stalls, the copy and
// the input channel wait with it. A new beat is taken only when that register
// is free or being emptied. After the end token every beat is taken and dropped
// until the next reset.
`timescale 1ns / 1ps
module lzss_window_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       end_of_stream
);

    lwd_pkg::lwd_cmd_t cmd;
    lwd_pkg::lwd_sts_t sts;

    lwd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .sts      (sts),
        .cmd      (cmd)
    );

    lwd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last),
        .end_of_stream (end_of_stream)
    );

endmodule

[verif/lzss_window_decompressor_checker.sv]
`timescale 1ns / 1ps
// Checker for the LZSS window decompressor: predicts and compares output beats.
module lzss_window_decompressor_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       last,
    input  logic       end_of_stream,
    input  logic       drain_done,
    output int         pending,
    output int         errors
);

    typedef enum logic [1:0] {
        PARSE_FLAG,
        PARSE_ITEM,
        PARSE_TOKEN_HI
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eos;
    } out_beat_t;

    logic [7:0]                     hist [lwd_pkg::WINDOW_SIZE];
    logic [lwd_pkg::WIN_ADDR_W-1:0] hist_wr;
    logic [7:0]                     flag_byte;
    logic [7:0]                     flag_sel;
    logic [7:0]                     token_lo;
    parse_state_t                   parse_state;
    logic                           stream_ended;
    logic                           drain_seen;
    out_beat_t                      expected_beats [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic emit_window_byte(input logic [7:0] b, input logic is_last);
        hist[hist_wr] = b;
        hist_wr = hist_wr + 1'b1;
        expected_beats.push_back('{data: b, last: is_last, eos: 1'b0});
    endtask

    task automatic next_item_slot();
        if (flag_sel[7])
        begin
            flag_sel = 8'h01;
            parse_state = PARSE_FLAG;
        end
        else
        begin
            flag_sel = flag_sel << 1;
            parse_state = PARSE_ITEM;
        end
    endtask

    task automatic decode_in_byte(input logic [7:0] b);
        logic [lwd_pkg::WIN_ADDR_W-1:0] src;
        int                             count;
        if (stream_ended)
            return;
        case (parse_state)
            PARSE_ITEM:
            begin
                if ((flag_sel & flag_byte) == 8'h00)
                begin
                    emit_window_byte(b, 1'b1);
                    next_item_slot();
                end
                else
                begin
                    token_lo = b;
                    parse_state = PARSE_TOKEN_HI;
                end
            end
            PARSE_TOKEN_HI:
            begin
                src = {b, token_lo[7:4]};
                if (src == '0)
                begin
                    expected_beats.push_back('{data: 8'h00, last: 1'b1, eos: 1'b1});
                    stream_ended = 1'b1;
                end
                else
                begin
                    // overlapping copy: each byte is read after the previous one is written
                    count = int'(token_lo[3:0]) + 2;
                    for (int i = 0; i < count; i++)
                    begin
                        emit_window_byte(hist[src], i == count - 1);
                        src = src + 1'b1;
                    end
                    next_item_slot();
                end
            end
            default:
            begin
                flag_byte = b;
                flag_sel = 8'h01;
                parse_state = PARSE_ITEM;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            for (int a = 0; a < lwd_pkg::WINDOW_SIZE; a++)
                hist[a] = 8'h00;
            hist_wr = lwd_pkg::WIN_ADDR_W'(1);
            flag_byte = 8'h00;
            flag_sel = 8'h01;
            token_lo = 8'h00;
            parse_state = PARSE_FLAG;
            stream_ended = 1'b0;
            drain_seen = 1'b0;
            expected_beats.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("unexpected beat: byte %02h last %0b eos %0b",
                                              out_byte, last, end_of_stream));
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_byte !== want.data || last !== want.last ||
                        end_of_stream !== want.eos)
                        report_mismatch($sformatf(
                            "beat byte %02h last %0b eos %0b, want byte %02h last %0b eos %0b",
                            out_byte, last, end_of_stream, want.data, want.last, want.eos));
                end
            end
            if (in_valid && in_ready)
                decode_in_byte(in_byte);
            if (drain_done && !drain_seen)
            begin
                drain_seen = 1'b1;
                if (expected_beats.size() != 0)
                    report_mismatch($sformatf("%0d expected beats never arrived",
                                              expected_beats.size()));
            end
            pending = expected_beats.size();
        end
    end

endmodule

[verif/lzss_window_decompressor_test.sv]
`timescale 1ns / 1ps
// Testbench top for the LZSS window decompressor: stimulus, handshake idling and verdict.
module lzss_window_decompressor_test;

    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BYTES  = 150;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] in_byte    = 8'h00;
    logic       out_ready  = 1'b0;
    logic       drain_done = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       last;
    logic       end_of_stream;
    int         pending;
    int         errors;

    int         tx_idle_pct;
    int         rx_idle_pct;
    int         quiet_cycles = 0;
    int         produced;
    logic [7:0] comp_stream [$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lzss_window_decompressor i_dut (.*);

    lzss_window_decompressor_checker i_checker (.*);

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_literal(input logic [7:0] b);
        comp_stream.push_back(b);
        produced++;
    endtask

    task automatic add_token(input logic [11:0] off, input logic [3:0] len_code);
        comp_stream.push_back({off[3:0], len_code});
        comp_stream.push_back(off[11:4]);
        produced += int'(len_code) + 2;
    endtask

    task automatic add_random_group();
        logic [7:0]  flags;
        logic [11:0] off;
        logic [3:0]  len_code;
        if ($urandom_range(0, 4) == 0)
            flags = 8'($urandom_range(0, 255));
        else
            for (int i = 0; i < 8; i++)
                flags[i] = ($urandom_range(0, 3) != 0);
        comp_stream.push_back(flags);
        for (int i = 0; i < 8; i++)
        begin
            if (!flags[i])
                add_literal(8'($urandom_range(0, 255)));
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: off = 12'(produced + 1 - $urandom_range(1, 4));
                    3:       off = 12'hFFF;
                    default: off = 12'($urandom_range(1, 4095));
                endcase
                if (off == '0)
                    off = 12'hFFF;
                if ($urandom_range(0, 3) == 0)
                    len_code = 4'($urandom_range(0, 15));
                else
                    len_code = 4'($urandom_range(8, 15));
                add_token(off, len_code);
            end
        end
    endtask

    task automatic wait_for_results();
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] lit_set [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        int         n;
        int         random_start;
        tx_idle_pct = 35;
        rx_idle_pct = 49;
        produced = 0;

        // literals at the byte extremes, then short, wrapping and overlapping matches
        comp_stream.push_back(8'h00);
        foreach (lit_set[i])
            add_literal(lit_set[i]);
        comp_stream.push_back(8'h0F);
        add_token(12'h001, 4'h0);
        add_token(12'hFFF, 4'hF);
        add_token(12'(produced), 4'hF);
        add_token(12'(produced - 1), 4'h7);
        add_literal(8'h33);
        add_literal(8'hCC);
        add_literal(8'h0F);
        add_literal(8'hF0);

        random_start = comp_stream.size();
        while (comp_stream.size() - random_start < RANDOM_BYTES)
            add_random_group();

        // end token, then bytes that must be dropped
        comp_stream.push_back({7'($urandom_range(0, 127)), 1'b1});
        comp_stream.push_back({4'h0, 4'($urandom_range(0, 15))});
        comp_stream.push_back(8'h00);
        repeat (6)
            comp_stream.push_back(8'($urandom_range(0, 255)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        n = comp_stream.size();
        for (int idx = 0; idx < n; idx++)
        begin
            if (idx == n / 3 || idx == 2 * n / 3)
            begin
                in_valid <= 1'b0;
                wait_for_results();
                if (idx == n / 3)
                begin
                    tx_idle_pct = 49;
                    rx_idle_pct = 35;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            end
            while ($urandom_range(0, 99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= comp_stream[idx];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        drain_done <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
